[src/plc_pkg.sv]
// ----------------------------------------------------------------------------
// plc_pkg: shared types and constants for the positional list store
// Sizes, action and status codes, and the control bundle sent to every cell.
// ----------------------------------------------------------------------------
package plc_pkg;

    // Storage sizes
    localparam int CAPACITY   = 16;
    localparam int DATA_WIDTH = 32;

    // Fixed field widths of the request and result ports
    localparam int ACT_W  = 2;
    localparam int POS_W  = 5;
    localparam int VAL_W  = 32;
    localparam int STAT_W = 2;
    localparam int OUT_W  = 32;
    localparam int CNT_W  = 5;

    // Internal widths derived from the capacity and the position width
    localparam int FILL_W = $clog2(CAPACITY + 1);
    localparam int CMP_W  = (POS_W > FILL_W) ? POS_W : FILL_W;

    typedef logic [DATA_WIDTH-1:0] t_word;
    typedef logic [CMP_W-1:0]      t_cmp;
    typedef logic [FILL_W-1:0]     t_fill;

    typedef enum logic [ACT_W-1:0] {
        ACT_INSERT = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_READ   = 2'd2,
        ACT_NONE   = 2'd3
    } t_action;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_INDEX = 2'd1,
        ST_EMPTY = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    // Control broadcast to every cell of the chain
    typedef struct packed {
        logic  shift_up;
        logic  shift_dn;
        t_cmp  pos;
        t_word value;
    } t_cell_ctrl;

endpackage

[src/plc_cell.sv]
// ----------------------------------------------------------------------------
// plc_cell: one slot of the list
// Holds one word; takes the left neighbor's word on an insert below it, the
// right neighbor's word on a remove at or below it, and the new word when it
// is the insert position. Drives its word onto the read bus when addressed.
// ----------------------------------------------------------------------------
module plc_cell
    import plc_pkg::*;
(
    input  logic       i_clk,
    input  t_cmp       i_index,
    input  t_cell_ctrl i_ctrl,
    input  t_word      i_prev,
    input  t_word      i_next,
    output t_word      o_data,
    output t_word      o_hit
);

    t_word r_data;
    t_word n_data;
    logic  w_at;
    logic  w_above;

    assign w_at    = (i_index == i_ctrl.pos);
    assign w_above = (i_index > i_ctrl.pos);

    // Pick the next word for this slot
    always_comb begin
        n_data = r_data;
        if (i_ctrl.shift_up) begin
            if (w_at) begin
                n_data = i_ctrl.value;
            end else if (w_above) begin
                n_data = i_prev;
            end
        end else if (i_ctrl.shift_dn) begin
            if (w_at || w_above) begin
                n_data = i_next;
            end
        end
    end

    // Hold the word
    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;
    assign o_hit  = w_at ? r_data : '0;

endmodule

[src/positional_list_store_top.sv]
// ----------------------------------------------------------------------------
// positional_list_store_top: bounded ordered list with positional access
// Result: o_done strobes in the cycle after its request is accepted.
// Throughput: one request per cycle; busy stays low, since the cell chain
// shifts the affected entries in the same cycle an insert or remove is taken.
// Reset (synchronous, active low) clears the count and the strobe; entry
// contents are undefined until written. The receiver cannot stall.
// ----------------------------------------------------------------------------
module positional_list_store_top
    import plc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [ACT_W-1:0]  i_action,
    input  logic [POS_W-1:0]  i_position,
    input  logic [VAL_W-1:0]  i_value,
    output logic              o_done,
    output logic [STAT_W-1:0] o_status,
    output logic [OUT_W-1:0]  o_data_out,
    output logic [CNT_W-1:0]  o_count
);

    t_fill      r_count;
    t_fill      n_count;
    t_status    n_status;
    t_word      n_data;
    logic       w_accept;
    t_action    w_act;
    t_cmp       w_pos;
    t_cmp       w_cnt;
    t_cell_ctrl w_ctrl;
    t_word      w_value;
    t_word      w_hit_or;
    logic [VAL_W+DATA_WIDTH-1:0] w_val_pad;
    logic [OUT_W+DATA_WIDTH-1:0] w_out_pad;
    logic [CNT_W+FILL_W-1:0]     w_cnt_pad;

    t_word w_data [CAPACITY];
    t_word w_hit  [CAPACITY];

    assign busy     = 1'b0;
    assign w_accept = start && !busy;
    assign w_act    = t_action'(i_action);
    assign w_pos    = CMP_W'(i_position);
    assign w_cnt    = CMP_W'(r_count);

    // Fit the request word to the stored width
    assign w_val_pad = {{DATA_WIDTH{1'b0}}, i_value};
    assign w_value   = w_val_pad[DATA_WIDTH-1:0];

    // Decide status, cell moves and next count
    always_comb begin
        n_status        = ST_OK;
        n_count         = r_count;
        w_ctrl.shift_up = 1'b0;
        w_ctrl.shift_dn = 1'b0;
        w_ctrl.pos      = w_pos;
        w_ctrl.value    = w_value;
        case (w_act)
            ACT_INSERT: begin
                if (w_pos > w_cnt) begin
                    n_status = ST_INDEX;
                end else if (r_count == FILL_W'(CAPACITY)) begin
                    n_status = ST_FULL;
                end else begin
                    w_ctrl.shift_up = w_accept;
                    n_count         = r_count + 1'b1;
                end
            end
            ACT_REMOVE, ACT_READ: begin
                if (r_count == '0) begin
                    n_status = ST_EMPTY;
                end else if (w_pos >= w_cnt) begin
                    n_status = ST_INDEX;
                end else if (w_act == ACT_REMOVE) begin
                    w_ctrl.shift_dn = w_accept;
                    n_count         = r_count - 1'b1;
                end
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    // Build the chain of cells
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        t_word w_prev;
        t_word w_next;
        if (g == 0) begin : g_first
            assign w_prev = '0;
        end else begin : g_mid_lo
            assign w_prev = w_data[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign w_next = w_data[g];
        end else begin : g_mid_hi
            assign w_next = w_data[g+1];
        end
        plc_cell u_cell (
            .i_clk   (i_clk),
            .i_index (CMP_W'(g)),
            .i_ctrl  (w_ctrl),
            .i_prev  (w_prev),
            .i_next  (w_next),
            .o_data  (w_data[g]),
            .o_hit   (w_hit[g])
        );
    end

    // Gather the addressed word
    always_comb begin
        w_hit_or = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            w_hit_or = w_hit_or | w_hit[k];
        end
    end

    // Data is returned only for a good remove or read
    assign n_data = ((w_act == ACT_REMOVE || w_act == ACT_READ) && n_status == ST_OK)
                    ? w_hit_or : '0;

    assign w_out_pad = {{OUT_W{1'b0}}, n_data};
    assign w_cnt_pad = {{CNT_W{1'b0}}, n_count};

    // Hold count and register the result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            o_done  <= 1'b0;
        end else begin
            o_done <= w_accept;
            if (w_accept) begin
                r_count <= n_count;
            end
        end
        if (w_accept) begin
            o_status   <= n_status;
            o_data_out <= w_out_pad[OUT_W-1:0];
            o_count    <= w_cnt_pad[CNT_W-1:0];
        end
    end

    // Count stays within capacity
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FILL_W'(CAPACITY))
        else $error("list count exceeds capacity");

    // A good insert grows the list by one
    a_insert_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_act == ACT_INSERT && n_status == ST_OK)
        |=> (r_count == $past(r_count) + 1'b1))
        else $error("insert did not grow the list");

    // An empty status always reports a zero count
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status == ST_EMPTY) |-> (o_count == '0))
        else $error("empty status with nonzero count");

    // A result strobe follows an accepted request
    a_done_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(w_accept))
        else $error("result strobe without a request");

endmodule
